[hw/rtl/ggs_pkg.sv]
// Shared types, constants and constant functions of the Gaussian glow pixel shader.
// Used by the top level, ggs_div and ggs_blob; depends on nothing else.
`default_nettype none

package ggs_pkg;

  // Wander rates and phase offset per glow, in Q0.32 turns.
  localparam logic [31:0] RATE_BASE  = 32'd75192180;
  localparam logic [31:0] RATE_STEP  = 32'd34178264;
  localparam logic [31:0] PHASE_STEP = 32'd1162060968;

  // Odd sine polynomial coefficients, Q1.30.
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  // Per-step decay of the halo table, Q0.32, and the exponent bits it covers.
  localparam logic [31:0] EXP_STEP = 32'd4278222805;
  localparam int          EXP_BITS = 12;
  // Exponent limit 3072 over the scale 128 of the exponent.
  localparam int          EXP_CUT  = 24;

  localparam logic [15:0] ONE_Q15   = 16'd32768;
  localparam logic [15:0] MIN_WIDTH = 16'd1311;

  // Field widths.
  localparam int X_W       = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEP = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOW_COLOR   = 3'd0,
    CFG_BASE_COLOR   = 3'd1,
    CFG_BLOB_COUNT   = 3'd2,
    CFG_GLOW_WIDTH   = 3'd3,
    CFG_WANDER_SPEED = 3'd4,
    CFG_STRIP_LENGTH = 3'd5
  } cfg_idx_t;

  // Repeated squaring of the decay step: base j is the step raised to 2^j.
  function automatic logic [31:0] exp_base(input int j);
    logic [63:0] b;
    b = {32'd0, EXP_STEP};
    for (int i = 0; i < j; i++) begin
      b = (b * b) >> 32;
    end
    return b[31:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gaussian_glow_pixel_shader_unit.sv]
// Top level of the Gaussian glow pixel shader: configuration, position divider,
// glow lanes, intensity sum and colour blend. Depends on ggs_pkg and all ggs_ modules.
`default_nettype none

// One pixel item is accepted in every cycle in which out_stall allows the pipeline
// to move; its colour passes through the input register, the position divider, a glow
// lane, the sum register and the blend register in that order. The pipeline depth is
// set by the pipelined restoring dividers, which settle two quotient bits per stage
// (position and halo exponent), and by the twelve multiply stages that form the halo
// decay. All glow lanes run side by side, so the glow count does not change the rate
// or the depth. While the output holds an item that is stalled, the whole pipeline
// holds and in_stall is raised.
// Configuration registers must only be written while no item is in flight.
module gaussian_glow_pixel_shader_unit #(
  parameter int MAX_BLOBS        = 8,
  parameter int MAX_LEDS         = 1024,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [31:0]                     in_frame_time,
  input  wire logic [9:0]                      in_led_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [7:0]                      out_red,
  output logic      [7:0]                      out_green,
  output logic      [7:0]                      out_blue,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ggs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ggs_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import ggs_pkg::*;

  localparam int X_LAT = (X_W + DIV_STEP - 1) / DIV_STEP;
  localparam int CW    = $clog2(MAX_BLOBS + 1);
  localparam int SW    = 16 + CW;

  // Configuration registers.
  logic [23:0] glow_color_r;
  logic [23:0] base_color_r;
  logic [3:0]  blob_count_r;
  logic [15:0] glow_width_r;
  logic [15:0] wander_speed_r;
  logic [10:0] strip_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glow_color_r   <= 24'h6078FF;
      base_color_r   <= 24'h000014;
      blob_count_r   <= 4'd3;
      glow_width_r   <= 16'd6554;
      wander_speed_r <= 16'd358;
      strip_length_r <= 11'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GLOW_COLOR:   glow_color_r   <= cfg_data[23:0];
        CFG_BASE_COLOR:   base_color_r   <= cfg_data[23:0];
        CFG_BLOB_COUNT:   blob_count_r   <= cfg_data[3:0];
        CFG_GLOW_WIDTH:   glow_width_r   <= cfg_data[15:0];
        CFG_WANDER_SPEED: wander_speed_r <= cfg_data[15:0];
        CFG_STRIP_LENGTH: strip_length_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Clamped settings derived from the registers.
  logic [10:0]   len_c;
  logic [10:0]   xden;
  logic          x_zero;
  logic [15:0]   w_c;
  logic [31:0]   w2_r;
  logic [CW-1:0] cnt_c;

  always_comb begin
    len_c  = (32'(strip_length_r) > MAX_LEDS) ? 11'(MAX_LEDS) : strip_length_r;
    x_zero = (len_c <= 11'd1);
    xden   = x_zero ? 11'd1 : (len_c - 11'd1);
    w_c    = (glow_width_r < MIN_WIDTH) ? MIN_WIDTH : glow_width_r;
    if (blob_count_r == 4'd0)                 cnt_c = CW'(1);
    else if (32'(blob_count_r) > MAX_BLOBS)   cnt_c = CW'(MAX_BLOBS);
    else                                      cnt_c = CW'(blob_count_r);
  end

  always_ff @(posedge clk) begin
    w2_r <= 32'(w_c) * 32'(w_c);
  end

  // The pipeline advances unless a finished item waits at a stalled output.
  logic out_valid_r;
  logic en;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Input register.
  logic        vld_a_r;
  logic [31:0] t_a_r;
  logic [9:0]  led_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  vld_a_r <= 1'b0;
    else if (en) vld_a_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a_r   <= in_frame_time;
      led_a_r <= in_led_index;
    end
  end

  // Pixel position along the strip, Q10.16.
  logic [X_W-1:0] x_q;
  logic [X_W-1:0] x_b;
  logic [31:0]    t_b;
  logic           vld_b;

  ggs_div #(.NW(X_W), .DW(11), .QW(X_W)) u_xdiv (
    .clk (clk),
    .en  (en),
    .num ({led_a_r, 16'd0}),
    .den (xden),
    .quo (x_q)
  );

  ggs_delay #(.W(32), .N(X_LAT)) u_t_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (t_a_r),
    .q     (t_b)
  );

  ggs_delay #(.W(1), .N(X_LAT)) u_vld_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (vld_a_r),
    .q     (vld_b)
  );

  assign x_b = x_zero ? '0 : x_q;

  // One lane per glow.
  logic [MAX_BLOBS-1:0] blob_vld;
  logic [15:0]          halo [MAX_BLOBS];

  for (genvar k = 0; k < MAX_BLOBS; k++) begin : g_blob
    ggs_blob #(.K(k), .DEPTH(SINE_TABLE_DEPTH)) u_blob (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_i   (vld_b),
      .t_i     (t_b),
      .x_i     (x_b),
      .speed_i (wander_speed_r),
      .w2_i    (w2_r),
      .vld_o   (blob_vld[k]),
      .halo_o  (halo[k])
    );
  end

  // Sum of the active halos, saturated at one.
  logic [SW-1:0] sum;
  logic [15:0]   light_r;
  logic          vld_l_r;

  always_comb begin
    sum = '0;
    for (int k = 0; k < MAX_BLOBS; k++) begin
      if (k < int'(cnt_c)) sum = sum + SW'(halo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  vld_l_r <= 1'b0;
    else if (en) vld_l_r <= blob_vld[0];
  end

  always_ff @(posedge clk) begin
    if (en) light_r <= (sum > SW'(ONE_Q15)) ? ONE_Q15 : sum[15:0];
  end

  // Blend from base colour toward glow colour, truncated to eight bits.
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [15:0] lvl);
    logic [23:0] mix;
    mix = 24'(a) * 24'(ONE_Q15 - lvl) + 24'(b) * 24'(lvl);
    return mix[22:15];
  endfunction

  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_l_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= blend(base_color_r[23:16], glow_color_r[23:16], light_r);
      green_r <= blend(base_color_r[15:8],  glow_color_r[15:8],  light_r);
      blue_r  <= blend(base_color_r[7:0],   glow_color_r[7:0],   light_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // All glow lanes carry the same item at the same time.
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (blob_vld != '0) |-> (blob_vld == {MAX_BLOBS{1'b1}}))
    else $error("glow lanes out of step");

  // The summed intensity never exceeds one.
  a_light_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_l_r |-> (light_r <= ONE_Q15))
    else $error("intensity above one");

  // A held output keeps the pipeline frozen, so the next item stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(light_r) && $stable(vld_l_r)))
    else $error("pipeline moved under a stalled output");

endmodule

`default_nettype wire

[hw/rtl/ggs_delay.sv]
// Enabled delay line of fixed length for side data and valid bits.
// Depends on nothing else.
`default_nettype none

module ggs_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  // Shift the whole line on each advance; reset empties it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[N-1];

endmodule

`default_nettype wire

[hw/rtl/ggs_div.sv]
// Pipelined restoring divider, DIV_STEP (two) quotient bits per stage, constant divisor.
// Depends on ggs_pkg for the number of bits per stage.
`default_nettype none

module ggs_div #(
  parameter int NW = 26,
  parameter int DW = 11,
  parameter int QW = 26
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);
  import ggs_pkg::*;

  localparam int NS = (QW + DIV_STEP - 1) / DIV_STEP;

  logic [DW-1:0] rem_r   [NS];
  logic [QW-1:0] low_r   [NS];
  logic [QW-1:0] quo_r   [NS];
  logic [DW-1:0] rem_nxt [NS];
  logic [QW-1:0] low_nxt [NS];
  logic [QW-1:0] quo_nxt [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;

    // The top dividend bits form the first partial remainder; it is below the divisor.
    if (s == 0) begin : g_first
      assign rem_in = DW'(num >> QW);
      assign low_in = QW'(num);
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // One compare and subtract per quotient bit.
    always_comb begin : p_step
      logic [DW:0] tr;
      logic        qb;
      tr = '0;
      qb = 1'b0;
      rem_nxt[s] = rem_in;
      low_nxt[s] = low_in;
      quo_nxt[s] = quo_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < QW) begin
          tr = {rem_nxt[s], low_nxt[s][QW-1]};
          low_nxt[s] = low_nxt[s] << 1;
          qb = (tr >= {1'b0, den});
          if (qb) tr = tr - {1'b0, den};
          quo_nxt[s] = (quo_nxt[s] << 1) | QW'(qb);
          rem_nxt[s] = tr[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_r[NS-1];

endmodule

`default_nettype wire

[hw/rtl/ggs_blob.sv]
// Halo of one wandering glow: phase, sine, position, distance, exponent, decay.
// Depends on ggs_pkg, ggs_div and ggs_delay.
`default_nettype none

module ggs_blob #(
  parameter int K     = 0,
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic [31:0]           t_i,
  input  wire logic [ggs_pkg::X_W-1:0] x_i,
  input  wire logic [15:0]           speed_i,
  input  wire logic [31:0]           w2_i,
  output logic                       vld_o,
  output logic      [15:0]           halo_o
);
  import ggs_pkg::*;

  localparam int IW  = $clog2(DEPTH);
  localparam int MW  = IW + 31;
  // Stages from the quadrant register to the sine argument.
  localparam int NA  = 2;
  localparam int NE  = (EXP_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int LAT = 14 + NA + NE + EXP_BITS;

  localparam logic [29:0] RATE_K =
    30'(64'(RATE_BASE) + 64'(RATE_STEP) * 64'(K));
  localparam logic [31:0] PH_K = 32'(64'(PHASE_STEP) * 64'(K));

  // Phase: time times the glow's rate, then times the speed, plus the glow's phase offset.
  logic [55:0] p1_r;
  logic [61:0] p1_full;
  logic [71:0] p2_full;
  logic [31:0] turn_r;

  assign p1_full = 62'(t_i) * 62'(RATE_K);
  assign p2_full = 72'(p1_r) * 72'(speed_i);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p1_full[55:0];
      turn_r <= p2_full[55:24] + PH_K;
    end
  end

  // Quarter-wave index, mirrored in odd quadrants, and the odd factor 2i+1 of the argument.
  logic [MW-1:0] im;
  logic [IW:0]   idx_w;
  logic [IW-1:0] idx;
  logic [IW:0]   odd_r;
  logic [1:0]    quad_r;

  assign im    = MW'(turn_r[29:0]) * MW'(DEPTH);
  assign idx_w = im[MW-1:30];

  always_comb begin
    if (32'(idx_w) >= 32'(DEPTH)) idx = IW'(DEPTH - 1);
    else                          idx = idx_w[IW-1:0];
    if (turn_r[30]) idx = IW'(DEPTH - 1) - idx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odd_r  <= {idx, 1'b1};
      quad_r <= turn_r[31:30];
    end
  end

  // Sine argument ((2i+1) << 29) / DEPTH in Q0.30: the whole part (2i+1) * Q_DEP plus
  // (2i+1) * R_DEP / DEPTH, the latter by a reciprocal multiplication that is exact
  // for every product below 2^(2*IW+1).
  localparam logic [63:0] P29   = 64'd1 << 29;
  localparam logic [63:0] Q_DEP = P29 / 64'(DEPTH);
  localparam logic [63:0] R_DEP = P29 % 64'(DEPTH);
  localparam int          YW    = 2 * IW + 1;
  localparam int          SH    = 3 * IW + 1;
  localparam int          RW    = 2 * IW + 3;
  localparam int          PW    = YW + RW;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

  logic [YW-1:0] y_full;
  logic [29:0]   base_full;
  logic [YW-1:0] y_r;
  logic [29:0]   base_r;
  logic [PW-1:0] yp;
  logic [29:0]   a_r;

  assign y_full    = YW'(odd_r) * YW'(R_DEP);
  assign base_full = 30'(odd_r) * 30'(Q_DEP);
  assign yp        = PW'(y_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      y_r    <= y_full;
      base_r <= base_full;
      a_r    <= base_r + 30'(yp >> SH);
    end
  end

  // Square of the argument.
  logic [59:0] asq;
  logic [29:0] a2_r;
  logic [29:0] ah_r;

  assign asq = 60'(a_r) * 60'(a_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= asq[59:30];
      ah_r <= a_r;
    end
  end

  // Horner steps of the odd polynomial, one coefficient per stage.
  logic [30:0] hc [4];
  logic [29:0] ha_r  [4];
  logic [29:0] ha2_r [4];
  logic [30:0] hr_r  [4];

  assign hc[0] = SIN_C7;
  assign hc[1] = SIN_C5;
  assign hc[2] = SIN_C3;
  assign hc[3] = SIN_C1;

  for (genvar h = 0; h < 4; h++) begin : g_horner
    logic [29:0] a_in;
    logic [29:0] a2_in;
    logic [30:0] r_in;
    logic [60:0] hp;

    if (h == 0) begin : g_first
      assign a_in  = ah_r;
      assign a2_in = a2_r;
      assign r_in  = SIN_C9;
    end else begin : g_next
      assign a_in  = ha_r[h-1];
      assign a2_in = ha2_r[h-1];
      assign r_in  = hr_r[h-1];
    end

    assign hp = 61'(a2_in) * 61'(r_in);

    always_ff @(posedge clk) begin
      if (en) begin
        ha_r[h]  <= a_in;
        ha2_r[h] <= a2_in;
        hr_r[h]  <= hc[h] - hp[60:30];
      end
    end
  end

  // Final product gives the sine in Q1.30.
  logic [60:0] sp;
  logic [30:0] s_r;

  assign sp = 61'(ha_r[3]) * 61'(hr_r[3]);

  always_ff @(posedge clk) begin
    if (en) s_r <= sp[60:30];
  end

  // Round to Q1.15, cap, and place the glow about the strip centre.
  logic [1:0]  quad_d;
  logic [16:0] v_rnd;
  logic [15:0] v;
  logic [15:0] pos_r;

  ggs_delay #(.W(2), .N(NA + 6)) u_quad_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (quad_r),
    .q     (quad_d)
  );

  assign v_rnd = 17'((32'(s_r) + 32'd16384) >> 15);
  assign v     = (v_rnd > 17'd32767) ? 16'd32767 : v_rnd[15:0];

  always_ff @(posedge clk) begin
    if (en) pos_r <= quad_d[1] ? (ONE_Q15 - v) : (ONE_Q15 + v);
  end

  // Distance to the pixel and its square.
  logic [X_W-1:0]   x_d;
  logic [X_W-1:0]   d_r;
  logic [2*X_W-1:0] dsq_r;

  ggs_delay #(.W(X_W), .N(NA + 10)) u_x_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (x_i),
    .q     (x_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= (x_d > X_W'(pos_r)) ? (x_d - X_W'(pos_r)) : (X_W'(pos_r) - x_d);
      dsq_r <= (2*X_W)'(d_r) * (2*X_W)'(d_r);
    end
  end

  // Halos past the table limit are dropped before the exponent division.
  logic [36:0] lim;
  logic        ovr_r;
  logic [43:0] nume_r;

  assign lim = 37'(w2_i) * 37'(EXP_CUT);

  always_ff @(posedge clk) begin
    if (en) begin
      ovr_r  <= (dsq_r >= (2*X_W)'(lim));
      nume_r <= (dsq_r >= (2*X_W)'(lim)) ? 44'd0 : {dsq_r[36:0], 7'd0};
    end
  end

  logic [EXP_BITS-1:0] n_q;
  logic                ovr_d;

  ggs_div #(.NW(44), .DW(32), .QW(EXP_BITS)) u_ediv (
    .clk (clk),
    .en  (en),
    .num (nume_r),
    .den (w2_i),
    .quo (n_q)
  );

  ggs_delay #(.W(1), .N(NE)) u_ovr_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (ovr_r),
    .q     (ovr_d)
  );

  // Binary powering of the decay step, low exponent bit first.
  logic [31:0]         acc_r [EXP_BITS];
  logic                one_r [EXP_BITS];
  logic [EXP_BITS-1:0] en_r  [EXP_BITS];
  logic                ov_r  [EXP_BITS];

  for (genvar j = 0; j < EXP_BITS; j++) begin : g_exp
    localparam logic [31:0] BJ = exp_base(j);
    logic [31:0]         acc_in;
    logic                one_in;
    logic [EXP_BITS-1:0] n_in;
    logic                ov_in;
    logic [63:0]         ep;

    if (j == 0) begin : g_first
      assign acc_in = '0;
      assign one_in = 1'b1;
      assign n_in   = n_q;
      assign ov_in  = ovr_d;
    end else begin : g_next
      assign acc_in = acc_r[j-1];
      assign one_in = one_r[j-1];
      assign n_in   = en_r[j-1];
      assign ov_in  = ov_r[j-1];
    end

    assign ep = 64'(acc_in) * 64'(BJ);

    always_ff @(posedge clk) begin
      if (en) begin
        en_r[j] <= n_in;
        ov_r[j] <= ov_in;
        if (n_in[j]) begin
          acc_r[j] <= one_in ? BJ : ep[63:32];
          one_r[j] <= 1'b0;
        end else begin
          acc_r[j] <= acc_in;
          one_r[j] <= one_in;
        end
      end
    end
  end

  // Round the decay to Q1.15.
  logic [32:0] acc_rnd;
  logic [15:0] halo_r;

  assign acc_rnd = (33'(acc_r[EXP_BITS-1]) + 33'd65536) >> 17;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ov_r[EXP_BITS-1])       halo_r <= '0;
      else if (one_r[EXP_BITS-1]) halo_r <= ONE_Q15;
      else                        halo_r <= acc_rnd[15:0];
    end
  end

  ggs_delay #(.W(1), .N(LAT)) u_vld_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (vld_i),
    .q     (vld_o)
  );

  assign halo_o = halo_r;

endmodule

`default_nettype wire
